// ----- rtl/core/mvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Sizes, command codes, register indexes, controller states and the
// command bundle from controller to datapath.
// ============================================================================
package mvm_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int DATA_WIDTH = 16;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int COLCNT_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROWCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ROWCNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(1);

    localparam logic CMD_VECTOR = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    localparam logic [COLCNT_W-1:0] COLCNT_MAX = COLCNT_W'(MAX_COLS);
    localparam logic [ROWCNT_W-1:0] ROWCNT_MAX = ROWCNT_W'(MAX_ROWS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC
    } t_state;

    typedef struct packed {
        logic vec_write;
        logic mat_load;
        logic mul_en;
        logic acc_en;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ----- rtl/core/mvm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mvm_ctrl: request sequencer
// Takes vector requests while staying idle; walks matrix requests through
// load, multiply and accumulate.
// ============================================================================
module mvm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_cmd,
    output mvm_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);
    import mvm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_cmd == CMD_MATRIX) begin
                        o_cmd.mat_load = 1'b1;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.vec_write = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/mvm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mvm_dp: vector store, multiplier, accumulator and position counters
// Holds the size registers and produces one result per finished row.
// ============================================================================
module mvm_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mvm_pkg::t_dp_cmd                     i_cmd,
    input  wire logic signed [mvm_pkg::DATA_WIDTH-1:0] i_value,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [mvm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mvm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                      o_valid,
    output logic [mvm_pkg::ROW_W-1:0]                 o_row_index,
    output logic signed [mvm_pkg::SUM_W-1:0]          o_dot_product,
    output logic                                      o_last_row
);
    import mvm_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_mem [MAX_COLS];

    logic [COLCNT_W-1:0]          r_col_count;
    logic [ROWCNT_W-1:0]          r_row_count;
    logic [COL_W-1:0]             r_fill;
    logic [COL_W-1:0]             r_col;
    logic [ROW_W-1:0]             r_row;
    logic signed [SUM_W-1:0]      r_sum;
    logic                         r_valid;

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] r_vec;
    logic signed [PROD_W-1:0]     r_prod;
    logic [ROW_W-1:0]             r_row_index;
    logic signed [SUM_W-1:0]      r_dot;
    logic                         r_last;

    logic [COLCNT_W-1:0]          cols_eff;
    logic [ROWCNT_W-1:0]          rows_eff;
    logic [COLCNT_W-1:0]          fill_inc;
    logic [COLCNT_W-1:0]          col_inc;
    logic [ROWCNT_W-1:0]          row_inc;
    logic                         col_done;
    logic                         row_last;
    logic signed [SUM_W-1:0]      sum_next;

    always_comb begin
        if (r_col_count == '0) begin
            cols_eff = COLCNT_W'(1);
        end else if (r_col_count > COLCNT_MAX) begin
            cols_eff = COLCNT_MAX;
        end else begin
            cols_eff = r_col_count;
        end
        if (r_row_count == '0) begin
            rows_eff = ROWCNT_W'(1);
        end else if (r_row_count > ROWCNT_MAX) begin
            rows_eff = ROWCNT_MAX;
        end else begin
            rows_eff = r_row_count;
        end
    end

    assign fill_inc = {1'b0, r_fill} + COLCNT_W'(1);
    assign col_inc  = {1'b0, r_col} + COLCNT_W'(1);
    assign row_inc  = {1'b0, r_row} + ROWCNT_W'(1);
    assign col_done = (col_inc >= cols_eff);
    assign row_last = (row_inc >= rows_eff);
    assign sum_next = r_sum + SUM_W'(r_prod);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= COLCNT_W'(1);
            r_row_count <= ROWCNT_W'(1);
            r_fill      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_sum       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= i_cmd.acc_en && col_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_COL_COUNT: r_col_count <= i_cfg_data[COLCNT_W-1:0];
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROWCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.vec_write) begin
                r_fill <= (fill_inc >= cols_eff) ? '0 : fill_inc[COL_W-1:0];
            end
            if (i_cmd.acc_en) begin
                if (col_done) begin
                    r_sum <= '0;
                    r_col <= '0;
                    r_row <= row_last ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_sum <= sum_next;
                    r_col <= col_inc[COL_W-1:0];
                end
            end
        end
    end

    // vector store and arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_write) begin
            r_mem[r_fill] <= i_value;
        end
        if (i_cmd.mat_load) begin
            r_value <= i_value;
            r_vec   <= r_mem[r_col];
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_value * r_vec;
        end
        if (i_cmd.acc_en && col_done) begin
            r_row_index <= r_row;
            r_dot       <= sum_next;
            r_last      <= row_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_row_index   = r_row_index;
    assign o_dot_product = r_dot;
    assign o_last_row    = r_last;

endmodule
`default_nettype wire

// ----- rtl/core/matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// matrix_vector_multiply: dense matrix times vector, fixed point
// Vector requests fill the vector store; matrix requests stream row-major
// and each completed row yields its index, Q24.24 dot product and last flag.
//
//   channel   handshake                 payload
//   request   start / busy              i_cmd, i_value
//   result    o_valid (one cycle)       o_row_index, o_dot_product, o_last_row
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A vector request leaves busy low.
// A matrix request steps through store read, multiply and accumulate.
// A row result appears in the cycle after the accumulate step of its last matrix request.
// Synchronous active-low reset clears positions, sum and sizes (1 x 1).
// The receiver cannot stall; config writes are always accepted.
// ============================================================================
module matrix_vector_multiply (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  i_cmd,
    input  wire logic signed [mvm_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                       o_valid,
    output logic [mvm_pkg::ROW_W-1:0]                  o_row_index,
    output logic signed [mvm_pkg::SUM_W-1:0]           o_dot_product,
    output logic                                       o_last_row,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [mvm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [mvm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mvm_pkg::*;

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = 1'b1;

    mvm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    mvm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_row_index   (o_row_index),
        .o_dot_product (o_dot_product),
        .o_last_row    (o_last_row)
    );

endmodule
`default_nettype wire

// ----- rtl/core/mvm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mvm_checker: port-level timing checks
// Request and result timing as seen on the top-level ports.
// ============================================================================
module mvm_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire logic i_cmd,
    input  wire logic o_valid
);
    import mvm_pkg::*;

    a_vector_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_VECTOR) |=> !busy)
        else $error("vector request left block busy");

    a_matrix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_MATRIX) |=> busy)
        else $error("matrix request did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid)
);
`default_nettype wire
